// ===== hw/rtl/skrt_pkg.sv =====
// skrt_pkg: shared types and operation codes for the sequence keyed resend table
// no dependencies

package skrt_pkg;

	localparam int SEQ_W = 16;
	localparam int HANDLE_W = 32;
	localparam int LEN_W = 16;
	localparam int OP_W = 2;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [HANDLE_W-1:0] handle;
		logic [LEN_W-1:0] length;
	} entry_t;

	typedef struct packed {
		logic wr;
		logic clr;
	} ring_cmd_t;

endpackage

// ===== hw/rtl/sequence_keyed_resend_table.sv =====
// sequence_keyed_resend_table: top level of the resend table
// depends on skrt_pkg, skrt_ring, skrt_scan
//
// Usage: a command beat is taken on a rising edge with start high and busy low.
// operation selects write (store sequence_number, payload_handle, payload_length
// as the newest entry, dropping the oldest when all ENTRIES slots are full),
// read (look up sequence_number, oldest match first) or clear (empty the table).
// Every command gives exactly one result beat, shown for one cycle with done
// high; found, found_handle and found_length are zero unless a read matched.
// The receiver cannot stall; results must be taken when done is high.
// Write, clear and the unused code finish at once: done follows on the
// next cycle and busy stays low, so such commands can come every cycle.
// A read walks the stored entries one per cycle through the single ring read
// port and key compare: busy stays high until every stored entry has been
// compared, or falls early on the first match; done comes on the cycle
// busy falls. A read of an empty table stores nothing and finishes like a write.
// Reset empties the table and clears busy and done; entry storage is not cleared
// and needs no sweep, since only filled slots are ever read.

module sequence_keyed_resend_table import skrt_pkg::*; #(
	parameter int ENTRIES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [OP_W-1:0] operation,
	input  logic [SEQ_W-1:0] sequence_number,
	input  logic [HANDLE_W-1:0] payload_handle,
	input  logic [LEN_W-1:0] payload_length,
	output logic done,
	output logic found,
	output logic [HANDLE_W-1:0] found_handle,
	output logic [LEN_W-1:0] found_length
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	ring_cmd_t cmd;
	entry_t wr_entry;
	entry_t rd_data;
	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] head;
	logic [CNT_W-1:0] count;

	skrt_ring #(
		.ENTRIES(ENTRIES)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.wr_entry(wr_entry),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.head(head),
		.count(count)
	);

	skrt_scan #(
		.ENTRIES(ENTRIES)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.sequence_number(sequence_number),
		.payload_handle(payload_handle),
		.payload_length(payload_length),
		.cmd(cmd),
		.wr_entry(wr_entry),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.head(head),
		.count(count),
		.done(done),
		.found(found),
		.found_handle(found_handle),
		.found_length(found_length)
	);

endmodule

// ===== hw/rtl/skrt_ring.sv =====
// skrt_ring: entry storage kept as a ring with head pointer and fill count
// depends on skrt_pkg

module skrt_ring import skrt_pkg::*; #(
	parameter int ENTRIES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  ring_cmd_t cmd,
	input  entry_t wr_entry,
	input  logic rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_addr,
	output entry_t rd_data,
	output logic [$clog2(ENTRIES)-1:0] head,
	output logic [$clog2(ENTRIES+1)-1:0] count
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	entry_t mem [ENTRIES];
	entry_t rd_data_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic full;
	logic [CNT_W:0] tail_sum;
	logic [IDX_W-1:0] tail_idx;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] wr_addr;

	assign full = (count_q == CNT_W'(ENTRIES));

	// first free slot, wrapped around the ring
	always_comb begin
		tail_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
		if (tail_sum >= (CNT_W+1)'(ENTRIES)) begin
			tail_sum = tail_sum - (CNT_W+1)'(ENTRIES);
		end
		tail_idx = tail_sum[IDX_W-1:0];
	end

	assign head_next = (head_q == IDX_W'(ENTRIES - 1)) ? '0 : head_q + 1'b1;
	// when full the oldest slot is the one overwritten
	assign wr_addr = full ? head_q : tail_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
		end else if (cmd.clr) begin
			count_q <= '0;
		end else if (cmd.wr) begin
			if (full) begin
				head_q <= head_next;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign head = head_q;
	assign count = count_q;

endmodule

// ===== hw/rtl/skrt_scan.sv =====
// skrt_scan: command sequencer and key compare unit that walks the ring on a read
// depends on skrt_pkg

module skrt_scan import skrt_pkg::*; #(
	parameter int ENTRIES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [OP_W-1:0] operation,
	input  logic [SEQ_W-1:0] sequence_number,
	input  logic [HANDLE_W-1:0] payload_handle,
	input  logic [LEN_W-1:0] payload_length,
	output ring_cmd_t cmd,
	output entry_t wr_entry,
	output logic rd_en,
	output logic [$clog2(ENTRIES)-1:0] rd_addr,
	input  entry_t rd_data,
	input  logic [$clog2(ENTRIES)-1:0] head,
	input  logic [$clog2(ENTRIES+1)-1:0] count,
	output logic done,
	output logic found,
	output logic [HANDLE_W-1:0] found_handle,
	output logic [LEN_W-1:0] found_length
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic [SEQ_W-1:0] key_q;
	logic [IDX_W-1:0] ptr_q;
	logic [CNT_W-1:0] left_q;
	logic pend_s1;
	logic last_s1;
	logic done_q;
	logic found_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [LEN_W-1:0] length_q;
	logic accept;
	logic issue;
	logic hit;

	assign busy = (state_q == ST_SCAN);
	assign accept = start && !busy;
	assign issue = busy && (left_q != '0);
	assign hit = pend_s1 && (rd_data.seq == key_q);

	assign cmd.wr = accept && (operation == OP_WRITE);
	assign cmd.clr = accept && (operation == OP_CLEAR);
	assign wr_entry.seq = sequence_number;
	assign wr_entry.handle = payload_handle;
	assign wr_entry.length = payload_length;

	assign rd_en = issue;
	assign rd_addr = ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q <= '0;
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept) begin
						// a read of an empty table finishes at once
						if (operation == OP_READ && count != '0) begin
							state_q <= ST_SCAN;
							left_q <= count;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						left_q <= left_q - 1'b1;
					end
					pend_s1 <= issue;
					last_s1 <= (left_q == CNT_W'(1));
					if (hit || (pend_s1 && last_s1)) begin
						state_q <= ST_IDLE;
						pend_s1 <= 1'b0;
						done_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= sequence_number;
			ptr_q <= head;
			found_q <= 1'b0;
			handle_q <= '0;
			length_q <= '0;
		end else if (busy) begin
			if (issue) begin
				ptr_q <= (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
			end
			// oldest match wins: scan runs from head toward newest
			if (hit) begin
				found_q <= 1'b1;
				handle_q <= rd_data.handle;
				length_q <= rd_data.length;
			end
		end
	end

	assign done = done_q;
	assign found = found_q;
	assign found_handle = handle_q;
	assign found_length = length_q;

endmodule
